// ----- rtl/gll_pkg.sv -----
// ----------------------------------------------------------------------------
// gll_pkg - shared types and constants for the GLL sentence parser
// Holds the parse phase enum, the header text and the digit arithmetic.
// ----------------------------------------------------------------------------
package gll_pkg;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_HDR,
    PH_HDR_COMMA,
    PH_LAT,
    PH_NS,
    PH_NS_COMMA,
    PH_LON,
    PH_EW,
    PH_EW_COMMA,
    PH_UTC,
    PH_STATUS
  } phase_t;

  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_ZERO   = 8'd48;
  localparam logic [3:0] HDR_LAST    = 4'd5;
  localparam logic [3:0] LAT_LAST    = 4'd9;
  localparam logic [3:0] LON_LAST    = 4'd10;
  localparam logic [6:0] W1          = 7'd1;
  localparam logic [6:0] W10         = 7'd10;
  localparam logic [6:0] W100        = 7'd100;

  // One result word: flags plus the held fix
  typedef struct packed {
    logic       message_valid;
    logic       fix_present;
    logic [7:0] lat_degrees;
    logic [7:0] lat_minutes;
    logic [7:0] lat_seconds;
    logic [7:0] north_south;
    logic [7:0] lon_degrees;
    logic [7:0] lon_minutes;
    logic [7:0] lon_seconds;
    logic [7:0] east_west;
  } result_t;

  // Expected header byte "$GPGLL" at each position
  function automatic logic [7:0] header_byte(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h47;
      3'd4:    c = 8'h4C;
      3'd5:    c = 8'h4C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // (byte - '0') * weight, modulo 256
  function automatic logic [7:0] digit_times(input logic [7:0] b, input logic [6:0] w);
    logic [7:0]  d;
    logic [14:0] prod;
    d    = b - CHAR_ZERO;
    prod = 15'(d) * 15'(w);
    return prod[7:0];
  endfunction

  // s * 60 / 100 = s * 3 / 5; divide by five through the reciprocal 205 / 1024,
  // exact for every value below 1024
  function automatic logic [7:0] scale_seconds(input logic [7:0] s);
    logic [9:0]  x;
    logic [17:0] y;
    x = 10'(s) * 10'd3;
    y = 18'(x) * 18'd205;
    return y[17:10];
  endfunction

endpackage

// ----- rtl/gll_sentence_parser_top.sv -----
// ----------------------------------------------------------------------------
// gll_sentence_parser_top - GLL position sentence parser
// Result words are registered into the output register or the skid register.
// Throughput: one byte per cycle while s_axis_tready is high; parsing is a
// single pass of logic from phase/work registers to the two-deep result buffer.
// Reset: rst (synchronous, high) returns to idle, clears the held fix, the
// fix-present flag and the result buffer.
// ----------------------------------------------------------------------------
// Bytes arrive on s_axis with tuser marking the first byte of a sentence and
// tlast the final one. The header "$GPGLL" is checked, then the latitude
// (ddmm.mmmm), its hemisphere, the longitude (dddmm.mmmm), its hemisphere,
// and the UTC field is skipped up to its comma. The status byte produces one
// result word; status 'A' latches the decoded fix into the held fix and sets
// the sticky fix-present flag. A header mismatch or an early tlast produces an
// invalid word. Each word carries the held fix.
//
// Results go through an output register backed by a skid register, so the
// parser keeps taking bytes while one word waits downstream; it stalls only
// when both are full.
// ----------------------------------------------------------------------------
module gll_sentence_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tuser,   // [0] first_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [7:0] lat_degrees, [15:8] lat_minutes,
                                      // [23:16] lat_seconds, [31:24] north_south,
                                      // [39:32] lon_degrees, [47:40] lon_minutes,
                                      // [55:48] lon_seconds, [63:56] east_west
  output logic [1:0]  m_axis_tuser    // [0] message_valid, [1] fix_present
);

  // Parser state
  gll_pkg::phase_t phase, phase_next;
  logic [3:0]      pos, pos_next;
  logic [7:0]      lat_work [3];
  logic [7:0]      lat_work_next [3];
  logic [7:0]      lon_work [3];
  logic [7:0]      lon_work_next [3];
  logic [7:0]      hemi_work [2];
  logic [7:0]      hemi_work_next [2];
  logic [7:0]      held_lat [3];
  logic [7:0]      held_lat_next [3];
  logic [7:0]      held_lon [3];
  logic [7:0]      held_lon_next [3];
  logic [7:0]      held_hemi [2];
  logic [7:0]      held_hemi_next [2];
  logic            fix_flag, fix_flag_next;

  // Result buffer: output register plus skid register
  logic               out_valid;
  gll_pkg::result_t   out_word;
  logic               skid_valid;
  gll_pkg::result_t   skid_word;

  logic               s_fire;
  logic               drain;
  logic               emit;
  logic               emit_ok;
  gll_pkg::result_t   new_word;

  // Working copies of the step
  gll_pkg::phase_t    ph;
  logic [3:0]         p;
  logic               done;
  logic [7:0]         b;

  assign s_axis_tready = !skid_valid;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign drain         = out_valid && m_axis_tready;
  assign b             = s_axis_tdata;

  // Parse step: next state and the result it causes
  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    for (int i = 0; i < 3; i++) begin
      lat_work_next[i] = lat_work[i];
      lon_work_next[i] = lon_work[i];
    end
    hemi_work_next[0] = hemi_work[0];
    hemi_work_next[1] = hemi_work[1];
    emit    = 1'b0;
    emit_ok = 1'b0;
    done    = 1'b0;
    ph      = phase;
    p       = pos;

    // A first byte abandons any open sentence and restarts the header check
    if (s_axis_tuser) begin
      for (int i = 0; i < 3; i++) begin
        lat_work_next[i] = 8'd0;
        lon_work_next[i] = 8'd0;
      end
      hemi_work_next[0] = 8'd0;
      hemi_work_next[1] = 8'd0;
      ph         = gll_pkg::PH_HDR;
      p          = 4'd0;
      phase_next = gll_pkg::PH_HDR;
      pos_next   = 4'd0;
    end

    if (ph != gll_pkg::PH_IDLE) begin
      unique case (ph)
        gll_pkg::PH_HDR: begin
          if (p > gll_pkg::HDR_LAST || b != gll_pkg::header_byte(p[2:0])) begin
            phase_next = gll_pkg::PH_IDLE;
            emit       = 1'b1;
            done       = 1'b1;
          end else if (p == gll_pkg::HDR_LAST) begin
            phase_next = gll_pkg::PH_HDR_COMMA;
          end else begin
            pos_next = p + 4'd1;
          end
        end
        gll_pkg::PH_HDR_COMMA: begin
          phase_next = gll_pkg::PH_LAT;
          pos_next   = 4'd0;
        end
        gll_pkg::PH_LAT: begin
          if (p == 4'd0 && b == gll_pkg::CHAR_COMMA) begin
            phase_next = gll_pkg::PH_NS;
          end else begin
            unique case (p)
              4'd0: lat_work_next[0] = gll_pkg::digit_times(b, gll_pkg::W10);
              4'd1: lat_work_next[0] = lat_work[0] + gll_pkg::digit_times(b, gll_pkg::W1);
              4'd2: lat_work_next[1] = gll_pkg::digit_times(b, gll_pkg::W10);
              4'd3: lat_work_next[1] = lat_work[1] + gll_pkg::digit_times(b, gll_pkg::W1);
              4'd5: lat_work_next[2] = gll_pkg::digit_times(b, gll_pkg::W10);
              4'd6: lat_work_next[2] = gll_pkg::scale_seconds(
                        lat_work[2] + gll_pkg::digit_times(b, gll_pkg::W1));
              default: ;
            endcase
            if (p >= gll_pkg::LAT_LAST) phase_next = gll_pkg::PH_NS;
            else                        pos_next   = p + 4'd1;
          end
        end
        gll_pkg::PH_NS: begin
          if (b == gll_pkg::CHAR_COMMA) begin
            phase_next = gll_pkg::PH_LON;
          end else begin
            hemi_work_next[0] = b;
            phase_next        = gll_pkg::PH_NS_COMMA;
          end
          pos_next = 4'd0;
        end
        gll_pkg::PH_NS_COMMA: begin
          phase_next = gll_pkg::PH_LON;
          pos_next   = 4'd0;
        end
        gll_pkg::PH_LON: begin
          if (p == 4'd0 && b == gll_pkg::CHAR_COMMA) begin
            phase_next = gll_pkg::PH_EW;
          end else begin
            unique case (p)
              4'd0: lon_work_next[0] = gll_pkg::digit_times(b, gll_pkg::W100);
              4'd1: lon_work_next[0] = lon_work[0] + gll_pkg::digit_times(b, gll_pkg::W10);
              4'd2: lon_work_next[0] = lon_work[0] + gll_pkg::digit_times(b, gll_pkg::W1);
              4'd3: lon_work_next[1] = gll_pkg::digit_times(b, gll_pkg::W10);
              4'd4: lon_work_next[1] = lon_work[1] + gll_pkg::digit_times(b, gll_pkg::W1);
              4'd6: lon_work_next[2] = gll_pkg::digit_times(b, gll_pkg::W10);
              4'd7: lon_work_next[2] = gll_pkg::scale_seconds(
                        lon_work[2] + gll_pkg::digit_times(b, gll_pkg::W1));
              default: ;
            endcase
            if (p >= gll_pkg::LON_LAST) phase_next = gll_pkg::PH_EW;
            else                        pos_next   = p + 4'd1;
          end
        end
        gll_pkg::PH_EW: begin
          if (b == gll_pkg::CHAR_COMMA) begin
            phase_next = gll_pkg::PH_UTC;
          end else begin
            hemi_work_next[1] = b;
            phase_next        = gll_pkg::PH_EW_COMMA;
          end
          pos_next = 4'd0;
        end
        gll_pkg::PH_EW_COMMA: begin
          phase_next = gll_pkg::PH_UTC;
        end
        gll_pkg::PH_UTC: begin
          if (b == gll_pkg::CHAR_COMMA) phase_next = gll_pkg::PH_STATUS;
        end
        gll_pkg::PH_STATUS: begin
          emit_ok    = (b == gll_pkg::CHAR_A);
          emit       = 1'b1;
          done       = 1'b1;
          phase_next = gll_pkg::PH_IDLE;
          pos_next   = 4'd0;
        end
        default: begin
          phase_next = gll_pkg::PH_IDLE;
          pos_next   = 4'd0;
          done       = 1'b1;
        end
      endcase

      // Early end of sentence: drop it with an invalid word
      if (!done && s_axis_tlast) begin
        phase_next = gll_pkg::PH_IDLE;
        pos_next   = 4'd0;
        emit       = 1'b1;
      end
    end
  end

  // Held fix: latch the decoded fix on a good status
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      held_lat_next[i] = emit_ok ? lat_work_next[i] : held_lat[i];
      held_lon_next[i] = emit_ok ? lon_work_next[i] : held_lon[i];
    end
    held_hemi_next[0] = emit_ok ? hemi_work_next[0] : held_hemi[0];
    held_hemi_next[1] = emit_ok ? hemi_work_next[1] : held_hemi[1];
    fix_flag_next     = fix_flag || emit_ok;

    new_word.message_valid = emit_ok;
    new_word.fix_present   = fix_flag_next;
    new_word.lat_degrees   = held_lat_next[0];
    new_word.lat_minutes   = held_lat_next[1];
    new_word.lat_seconds   = held_lat_next[2];
    new_word.north_south   = held_hemi_next[0];
    new_word.lon_degrees   = held_lon_next[0];
    new_word.lon_minutes   = held_lon_next[1];
    new_word.lon_seconds   = held_lon_next[2];
    new_word.east_west     = held_hemi_next[1];
  end

  // Parser and held-fix registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= gll_pkg::PH_IDLE;
      pos      <= 4'd0;
      fix_flag <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        lat_work[i] <= 8'd0;
        lon_work[i] <= 8'd0;
        held_lat[i] <= 8'd0;
        held_lon[i] <= 8'd0;
      end
      for (int i = 0; i < 2; i++) begin
        hemi_work[i] <= 8'd0;
        held_hemi[i] <= 8'd0;
      end
    end else if (s_fire) begin
      phase    <= phase_next;
      pos      <= pos_next;
      fix_flag <= fix_flag_next;
      for (int i = 0; i < 3; i++) begin
        lat_work[i] <= lat_work_next[i];
        lon_work[i] <= lon_work_next[i];
        held_lat[i] <= held_lat_next[i];
        held_lon[i] <= held_lon_next[i];
      end
      for (int i = 0; i < 2; i++) begin
        hemi_work[i] <= hemi_work_next[i];
        held_hemi[i] <= held_hemi_next[i];
      end
    end
  end

  // Result buffer: advance the skid word on a drain, park a new word in the
  // skid register when the output register is held
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (drain) begin
        if (skid_valid) begin
          out_word   <= skid_word;
          skid_valid <= 1'b0;
        end else if (s_fire && emit) begin
          out_word <= new_word;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (out_valid) begin
        if (s_fire && emit) begin
          skid_word  <= new_word;
          skid_valid <= 1'b1;
        end
      end else if (s_fire && emit) begin
        out_word  <= new_word;
        out_valid <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = {out_word.fix_present, out_word.message_valid};
  assign m_axis_tdata  = {out_word.east_west,   out_word.lon_seconds,
                          out_word.lon_minutes, out_word.lon_degrees,
                          out_word.north_south, out_word.lat_seconds,
                          out_word.lat_minutes, out_word.lat_degrees};

endmodule
